### design/bli_pkg.sv
// Shared types, constants and control structures for the bounded list engine.
package bli_pkg;

    // Storage size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the stream payloads
    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int LEN_W = 5;
    localparam int ST_W  = 2;
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = ((VAL_W + POS_W + LEN_W + 7) / 8) * 8;
    localparam int M_TUSER_W = ST_W;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CMP_W-1:0] cmp_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [VAL_W-1:0] val_t;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_READ     = 3'd1,
        OP_TRAVERSE = 3'd2,
        OP_REVERSE  = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // Datapath selections
    typedef enum logic [1:0] {RA_LO, RA_LO_INC, RA_POS}           ra_sel_t;
    typedef enum logic [1:0] {WA_LO, WA_HI, WA_POS}               wa_sel_t;
    typedef enum logic [1:0] {WD_RDATA_A, WD_RDATA_B, WD_VAL}     wd_sel_t;
    typedef enum logic [2:0] {LO_HOLD, LO_ZERO, LO_CNT_M1, LO_INC, LO_DEC} lo_op_t;
    typedef enum logic [1:0] {HI_HOLD, HI_CNT_M1, HI_LO_INC, HI_DEC} hi_op_t;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_CLEAR}       cnt_op_t;
    typedef enum logic [1:0] {VS_ZERO, VS_VAL, VS_RDATA}          val_sel_t;
    typedef enum logic [1:0] {PS_ZERO, PS_POS, PS_LO_INC}         pos_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        ra_sel_t  ra_sel;
        logic     rb_next;
        logic     we;
        wa_sel_t  wa_sel;
        wd_sel_t  wd_sel;
        lo_op_t   lo_op;
        hi_op_t   hi_op;
        cnt_op_t  cnt_op;
        logic     out_load;
        status_t  out_status;
        val_sel_t out_val_sel;
        pos_sel_t out_pos_sel;
        logic     out_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            ins_ok;
        logic            ins_append;
        logic            rd_ok;
        logic            empty;
        logic            short_list;
        logic            lo_at_pos;
        logic            trv_last;
        logic            more_swaps;
        logic            out_free;
    } stat_t;

endpackage

### design/bli_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module bli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_a,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Both read ports, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### design/bli_ctrl.sv
// Controller state machine that sequences every list operation.
module bli_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  bli_pkg::stat_t stat,
    output bli_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_FIRST,
        S_INS_SHIFT,
        S_INS_LAST,
        S_INS_PUT,
        S_TRV_RD,
        S_TRV_EMIT,
        S_REV_RD,
        S_REV_WLO,
        S_REV_WHI,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    bli_pkg::status_t    res_status_reg, res_status_next;
    bli_pkg::val_sel_t   res_val_reg, res_val_next;
    bli_pkg::pos_sel_t   res_pos_reg, res_pos_next;

    // A new transaction is taken only between operations.
    assign s_tready = (state_reg == S_IDLE);

    // Next state, pending result and datapath commands
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_pos_next    = res_pos_reg;
        cmd             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_status_next = bli_pkg::ST_OK;
                res_val_next    = bli_pkg::VS_ZERO;
                res_pos_next    = bli_pkg::PS_ZERO;
                state_next      = S_EMIT;
                case (stat.op)
                    bli_pkg::OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            res_status_next = bli_pkg::ST_FULL;
                        end
                        else if (!stat.ins_ok)
                        begin
                            res_status_next = bli_pkg::ST_BADPOS;
                        end
                        else if (stat.ins_append)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            cmd.lo_op  = bli_pkg::LO_CNT_M1;
                            state_next = S_INS_FIRST;
                        end
                    end
                    bli_pkg::OP_READ:
                    begin
                        if (!stat.rd_ok)
                        begin
                            res_status_next = bli_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            cmd.rd_en    = 1'b1;
                            cmd.ra_sel   = bli_pkg::RA_POS;
                            res_val_next = bli_pkg::VS_RDATA;
                            res_pos_next = bli_pkg::PS_POS;
                        end
                    end
                    bli_pkg::OP_TRAVERSE:
                    begin
                        if (stat.empty)
                        begin
                            res_status_next = bli_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.lo_op  = bli_pkg::LO_ZERO;
                            state_next = S_TRV_RD;
                        end
                    end
                    bli_pkg::OP_REVERSE:
                    begin
                        if (!stat.short_list)
                        begin
                            cmd.lo_op  = bli_pkg::LO_ZERO;
                            cmd.hi_op  = bli_pkg::HI_CNT_M1;
                            state_next = S_REV_RD;
                        end
                    end
                    bli_pkg::OP_CLEAR:
                    begin
                        cmd.cnt_op = bli_pkg::CNT_CLEAR;
                    end
                    default:
                    begin
                        // Unused codes give no result.
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Move entries up one place, top first, overlapping read and write.
            S_INS_FIRST, S_INS_SHIFT:
            begin
                if (state_reg == S_INS_SHIFT)
                begin
                    cmd.we     = 1'b1;
                    cmd.wa_sel = bli_pkg::WA_HI;
                    cmd.wd_sel = bli_pkg::WD_RDATA_A;
                end
                cmd.rd_en  = 1'b1;
                cmd.ra_sel = bli_pkg::RA_LO;
                cmd.hi_op  = bli_pkg::HI_LO_INC;
                cmd.lo_op  = bli_pkg::LO_DEC;
                state_next = stat.lo_at_pos ? S_INS_LAST : S_INS_SHIFT;
            end

            S_INS_LAST:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = bli_pkg::WA_HI;
                cmd.wd_sel = bli_pkg::WD_RDATA_A;
                state_next = S_INS_PUT;
            end

            S_INS_PUT:
            begin
                cmd.we          = 1'b1;
                cmd.wa_sel      = bli_pkg::WA_POS;
                cmd.wd_sel      = bli_pkg::WD_VAL;
                cmd.cnt_op      = bli_pkg::CNT_INC;
                res_status_next = bli_pkg::ST_OK;
                res_val_next    = bli_pkg::VS_VAL;
                res_pos_next    = bli_pkg::PS_POS;
                state_next      = S_EMIT;
            end

            S_TRV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.ra_sel = bli_pkg::RA_LO;
                state_next = S_TRV_EMIT;
            end

            // One element out per free output slot, next read issued alongside.
            S_TRV_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = bli_pkg::ST_OK;
                    cmd.out_val_sel = bli_pkg::VS_RDATA;
                    cmd.out_pos_sel = bli_pkg::PS_LO_INC;
                    cmd.out_last    = stat.trv_last;
                    if (stat.trv_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.ra_sel = bli_pkg::RA_LO_INC;
                        cmd.lo_op  = bli_pkg::LO_INC;
                    end
                end
            end

            S_REV_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.ra_sel = bli_pkg::RA_LO;
                state_next = S_REV_WLO;
            end

            S_REV_WLO:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = bli_pkg::WA_LO;
                cmd.wd_sel = bli_pkg::WD_RDATA_B;
                state_next = S_REV_WHI;
            end

            // Finish the swap and fetch the next inner pair, if any.
            S_REV_WHI:
            begin
                cmd.we     = 1'b1;
                cmd.wa_sel = bli_pkg::WA_HI;
                cmd.wd_sel = bli_pkg::WD_RDATA_A;
                cmd.lo_op  = bli_pkg::LO_INC;
                cmd.hi_op  = bli_pkg::HI_DEC;
                if (stat.more_swaps)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ra_sel  = bli_pkg::RA_LO_INC;
                    cmd.rb_next = 1'b1;
                    state_next  = S_REV_WLO;
                end
                else
                begin
                    res_status_next = bli_pkg::ST_OK;
                    res_val_next    = bli_pkg::VS_ZERO;
                    res_pos_next    = bli_pkg::PS_ZERO;
                    state_next      = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_status  = res_status_reg;
                    cmd.out_val_sel = res_val_reg;
                    cmd.out_pos_sel = res_pos_reg;
                    cmd.out_last    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and pending result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= bli_pkg::ST_OK;
            res_val_reg    <= bli_pkg::VS_ZERO;
            res_pos_reg    <= bli_pkg::PS_ZERO;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_val_reg    <= res_val_next;
            res_pos_reg    <= res_pos_next;
        end
    end

endmodule

### design/bli_datapath.sv
// Datapath: item registers, walk pointers, element RAM, count and output register.
module bli_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bli_pkg::cmd_t                   cmd,
    output bli_pkg::stat_t                  stat,
    input  logic [bli_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [bli_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bli_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [bli_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);

    logic [bli_pkg::OP_W-1:0] op_reg;
    bli_pkg::pos_t            pos_reg;
    bli_pkg::val_t            val_reg;
    bli_pkg::cnt_t            count_reg, count_next;
    bli_pkg::cnt_t            lo_reg, lo_next;
    bli_pkg::cnt_t            hi_reg, hi_next;

    bli_pkg::cmp_t            pos_c, cnt_c, lo_c, hi_c, pos_m1;
    bli_pkg::cnt_t            lo_inc, hi_dec;

    logic                     ram_we;
    bli_pkg::idx_t            ram_waddr, ram_raddr_a, ram_raddr_b;
    bli_pkg::val_t            ram_wdata, rdata_a, rdata_b;

    logic                     m_valid_reg, m_valid_next;
    bli_pkg::status_t         status_out_reg;
    bli_pkg::val_t            value_out_reg;
    bli_pkg::pos_t            pos_out_reg;
    bli_pkg::len_t            len_out_reg;
    logic                     last_out_reg;

    // Widened copies for comparisons
    assign pos_c  = bli_pkg::cmp_t'(pos_reg);
    assign cnt_c  = bli_pkg::cmp_t'(count_reg);
    assign lo_c   = bli_pkg::cmp_t'(lo_reg);
    assign hi_c   = bli_pkg::cmp_t'(hi_reg);
    assign pos_m1 = pos_c - bli_pkg::cmp_t'(1);
    assign lo_inc = lo_reg + bli_pkg::cnt_t'(1);
    assign hi_dec = hi_reg - bli_pkg::cnt_t'(1);

    // Status to the controller
    always_comb
    begin
        stat.op         = op_reg;
        stat.full       = (count_reg >= bli_pkg::cnt_t'(bli_pkg::CAPACITY));
        stat.ins_ok     = (pos_c != '0) && (pos_c <= cnt_c + bli_pkg::cmp_t'(1));
        stat.ins_append = (pos_c == cnt_c + bli_pkg::cmp_t'(1));
        stat.rd_ok      = (pos_c != '0) && (pos_c <= cnt_c);
        stat.empty      = (count_reg == '0);
        stat.short_list = (cnt_c <= bli_pkg::cmp_t'(1));
        stat.lo_at_pos  = (lo_c + bli_pkg::cmp_t'(1) == pos_c);
        stat.trv_last   = (lo_c + bli_pkg::cmp_t'(1) == cnt_c);
        stat.more_swaps = (lo_c + bli_pkg::cmp_t'(2) < hi_c);
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // Captured transaction fields
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= s_tuser;
            pos_reg <= s_tdata[bli_pkg::POS_W-1:0];
            val_reg <= s_tdata[bli_pkg::POS_W +: bli_pkg::VAL_W];
        end
    end

    // Walk pointers and element count
    always_comb
    begin
        case (cmd.lo_op)
            bli_pkg::LO_ZERO:   lo_next = '0;
            bli_pkg::LO_CNT_M1: lo_next = count_reg - bli_pkg::cnt_t'(1);
            bli_pkg::LO_INC:    lo_next = lo_inc;
            bli_pkg::LO_DEC:    lo_next = lo_reg - bli_pkg::cnt_t'(1);
            default:            lo_next = lo_reg;
        endcase
        case (cmd.hi_op)
            bli_pkg::HI_CNT_M1: hi_next = count_reg - bli_pkg::cnt_t'(1);
            bli_pkg::HI_LO_INC: hi_next = lo_inc;
            bli_pkg::HI_DEC:    hi_next = hi_dec;
            default:            hi_next = hi_reg;
        endcase
        case (cmd.cnt_op)
            bli_pkg::CNT_INC:   count_next = count_reg + bli_pkg::cnt_t'(1);
            bli_pkg::CNT_CLEAR: count_next = '0;
            default:            count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Element RAM addressing
    always_comb
    begin
        case (cmd.ra_sel)
            bli_pkg::RA_LO_INC: ram_raddr_a = lo_inc[bli_pkg::IDX_W-1:0];
            bli_pkg::RA_POS:    ram_raddr_a = pos_m1[bli_pkg::IDX_W-1:0];
            default:            ram_raddr_a = lo_reg[bli_pkg::IDX_W-1:0];
        endcase
        ram_raddr_b = cmd.rb_next ? hi_dec[bli_pkg::IDX_W-1:0] : hi_reg[bli_pkg::IDX_W-1:0];
        case (cmd.wa_sel)
            bli_pkg::WA_LO:  ram_waddr = lo_reg[bli_pkg::IDX_W-1:0];
            bli_pkg::WA_POS: ram_waddr = pos_m1[bli_pkg::IDX_W-1:0];
            default:         ram_waddr = hi_reg[bli_pkg::IDX_W-1:0];
        endcase
        case (cmd.wd_sel)
            bli_pkg::WD_RDATA_B: ram_wdata = rdata_b;
            bli_pkg::WD_VAL:     ram_wdata = val_reg;
            default:             ram_wdata = rdata_a;
        endcase
        ram_we = cmd.we;
    end

    bli_ram #(
        .WIDTH (bli_pkg::VAL_W),
        .DEPTH (bli_pkg::CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .rd_en   (cmd.rd_en),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Output register: valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register: result fields
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_out_reg <= cmd.out_status;
            last_out_reg   <= cmd.out_last;
            len_out_reg    <= bli_pkg::len_t'(count_reg);
            case (cmd.out_val_sel)
                bli_pkg::VS_VAL:   value_out_reg <= val_reg;
                bli_pkg::VS_RDATA: value_out_reg <= rdata_a;
                default:           value_out_reg <= '0;
            endcase
            case (cmd.out_pos_sel)
                bli_pkg::PS_POS:    pos_out_reg <= pos_reg;
                bli_pkg::PS_LO_INC: pos_out_reg <= bli_pkg::pos_t'(lo_c + bli_pkg::cmp_t'(1));
                default:            pos_out_reg <= '0;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_out_reg;
    assign m_tuser  = status_out_reg;
    assign m_tdata  = bli_pkg::M_TDATA_W'({len_out_reg, pos_out_reg, value_out_reg});

endmodule

### design/bounded_list_insert_reverse_top.sv
// Top level of the bounded list engine: controller and datapath joined.
//
//  Channel   Direction  Handshake                    Payload (lowest bit first)
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser: operation[2:0];
//                                                    tdata: position[4:0], value_in[36:5]
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: value_out[31:0],
//                                                    position_out[36:32], length[41:37];
//                                                    tuser: status; tlast: last
//
// One operation at a time; s_axis_tready is high only between operations. An insert that
// moves entries up moves one entry per cycle through the single write port, and a traverse
// emits one element per cycle while m_axis_tready is high. Reset clears the element count,
// the output valid flag and control state only; a stall on m_axis holds the result.
module bounded_list_insert_reverse_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // position, value_in, zero fill
    input  logic [bli_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation
    input  logic [bli_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // value_out, position_out, length, zero fill
    output logic [bli_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [bli_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tlast
);

    bli_pkg::cmd_t  cmd;
    bli_pkg::stat_t stat;

    // Sequencing of each operation
    bli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage, pointers and result register
    bli_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule
